FILE: rtl/core/lpd_pkg.sv
// ----------------------------------------------------------------------------
// lpd_pkg
// Shared types and constants of the length prefix deframer: per-channel
// context layout, result record, operation and result kind codes.
// ----------------------------------------------------------------------------
package lpd_pkg;

	localparam int CHAN_W  = 4;
	localparam int BYTE_W  = 8;
	localparam int KIND_W  = 2;
	localparam int PHASE_W = 3;
	localparam int ACC_W   = 32;

	// Highest channel count the channel field can address
	localparam int CHAN_SPAN = 1 << CHAN_W;

	// Operation codes of an input transaction
	localparam logic OP_DATA  = 1'b0;
	localparam logic OP_CLOSE = 1'b1;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_BODY  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

	// Context phases: 0..3 count header bytes seen
	localparam logic [PHASE_W-1:0] PH_HDR_LAST   = 3'd3;
	localparam logic [PHASE_W-1:0] PH_BODY_FIRST = 3'd4;
	localparam logic [PHASE_W-1:0] PH_BODY_MORE  = 3'd5;

	// Header length, which the frame length counts too
	localparam logic [ACC_W-1:0] HDR_BYTES = 32'd4;

	typedef struct packed {
		logic [PHASE_W-1:0] phase;
		logic [ACC_W-1:0]   acc;
	} lpd_ctx_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CHAN_W-1:0] out_channel;
		logic [BYTE_W-1:0] body_byte;
		logic              first;
		logic              last;
	} lpd_res_t;

endpackage

FILE: rtl/core/lpd_link_if.sv
// ----------------------------------------------------------------------------
// lpd_link_if
// Input channel: one received byte or a close event per transaction.
// ----------------------------------------------------------------------------
interface lpd_link_if;
	logic                        valid;
	logic                        ready;
	logic                        op;
	logic [lpd_pkg::CHAN_W-1:0]  channel;
	logic [lpd_pkg::BYTE_W-1:0]  data_byte;

	modport source(output valid, output op, output channel, output data_byte, input ready);
	modport sink(input valid, input op, input channel, input data_byte, output ready);
endinterface

FILE: rtl/core/lpd_msg_if.sv
// ----------------------------------------------------------------------------
// lpd_msg_if
// Output channel: one message byte, empty message or length error per
// transaction.
// ----------------------------------------------------------------------------
interface lpd_msg_if;
	logic                        valid;
	logic                        ready;
	logic [lpd_pkg::KIND_W-1:0]  kind;
	logic [lpd_pkg::CHAN_W-1:0]  out_channel;
	logic [lpd_pkg::BYTE_W-1:0]  body_byte;
	logic                        first;
	logic                        last;

	modport source(output valid, output kind, output out_channel, output body_byte,
		output first, output last, input ready);
	modport sink(input valid, input kind, input out_channel, input body_byte,
		input first, input last, output ready);
endinterface

FILE: rtl/core/multichannel_length_prefix_deframer.sv
// ----------------------------------------------------------------------------
// multichannel_length_prefix_deframer
// Splits interleaved byte streams of many connections into messages framed
// by a 4-byte big-endian length prefix.
// ----------------------------------------------------------------------------
// Usage:
//   link carries one transaction per received byte (op data) or per
//   connection close (op close), tagged with its channel. msg carries the
//   results: body bytes with first/last marks, an empty-message mark for a
//   frame length of four, or a length error for a length below four.
//   Header bytes and closes give no result; channels at or above CHANNELS
//   are accepted and dropped.
//   Throughput: one link transaction per cycle unless a stall holds the update
//   stage. The context of each channel lives in a memory read in the accept
//   cycle and written back when the update stage advances; a write to the entry
//   being read is forwarded. A result is registered before it is valid on msg.
//   Reset: every channel starts hunting for a header; per-entry valid bits
//   clear at once, so no clearing pass is needed.
//   Stall: a held result blocks only an update that has a result of its
//   own; the update stage then holds and link.ready drops.
// ----------------------------------------------------------------------------
module multichannel_length_prefix_deframer #(
	parameter int CHANNELS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	lpd_link_if.sink   link,
	lpd_msg_if.source  msg
);

	// Only channels the channel field can name need a context
	localparam int Depth = (CHANNELS < lpd_pkg::CHAN_SPAN) ? CHANNELS : lpd_pkg::CHAN_SPAN;
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

	// Accept stage
	logic              in_acc;
	logic              in_range;

	// Update stage
	logic                        valid_s1;
	logic                        op_s1;
	logic [AddrW-1:0]            addr_s1;
	logic [lpd_pkg::CHAN_W-1:0]  chan_s1;
	logic [lpd_pkg::BYTE_W-1:0]  byte_s1;
	lpd_pkg::lpd_ctx_t           ctx_s1;
	lpd_pkg::lpd_ctx_t           ctx_next;
	logic                        has_res;
	lpd_pkg::lpd_res_t           res;
	logic                        adv_s1;

	// Output register
	logic              out_valid_q;
	lpd_pkg::lpd_res_t out_q;

	assign in_acc   = link.valid && link.ready;
	assign in_range = int'(link.channel) < CHANNELS;

	// Advance unless a result would overwrite one still waiting on msg
	assign adv_s1     = valid_s1 && (!has_res || !out_valid_q || msg.ready);
	assign link.ready = !valid_s1 || adv_s1;

	lpd_ctx_store #(
		.DEPTH  (Depth),
		.ADDR_W (AddrW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.rd_addr (link.channel[AddrW-1:0]),
		.wr_en   (adv_s1),
		.wr_addr (addr_s1),
		.wr_data (ctx_next),
		.rd_ctx  (ctx_s1)
	);

	lpd_step u_step (
		.op        (op_s1),
		.channel   (chan_s1),
		.data_byte (byte_s1),
		.ctx       (ctx_s1),
		.ctx_next  (ctx_next),
		.has_res   (has_res),
		.res       (res)
	);

	// Capture the transaction alongside its context read
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_s1   <= link.op;
			addr_s1 <= link.channel[AddrW-1:0];
			chan_s1 <= link.channel;
			byte_s1 <= link.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (link.ready) begin
			// drop out-of-range channels right at the accept
			valid_s1 <= in_acc && in_range;
		end
	end

	// Hold a result until msg takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && has_res) begin
			out_valid_q <= 1'b1;
		end else if (msg.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && has_res) begin
			out_q <= res;
		end
	end

	assign msg.valid       = out_valid_q;
	assign msg.kind        = out_q.kind;
	assign msg.out_channel = out_q.out_channel;
	assign msg.body_byte   = out_q.body_byte;
	assign msg.first       = out_q.first;
	assign msg.last        = out_q.last;

`ifndef SYNTHESIS
	// Context read back, forwarded or not, never holds an unused phase
	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (ctx_s1.phase <= lpd_pkg::PH_BODY_MORE))
		else $error("context phase out of range");

	// A blocked update with a result must still be there next cycle
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && has_res && out_valid_q && !msg.ready) |=> valid_s1)
		else $error("update stage lost a stalled result");

	// Empty messages close the message, errors carry no marks
	a_empty_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(msg.valid && msg.kind == lpd_pkg::KIND_EMPTY) |-> (msg.last && !msg.first))
		else $error("empty message marks wrong");

	a_error_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(msg.valid && msg.kind == lpd_pkg::KIND_ERROR) |-> (!msg.last && !msg.first))
		else $error("error result marks wrong");
`endif

endmodule

FILE: rtl/core/lpd_ctx_store.sv
// ----------------------------------------------------------------------------
// lpd_ctx_store
// Per-channel context memory with registered read, valid bits
// that make unwritten entries read as zero, and forwarding of a write that
// lands on the entry being read in the same cycle.
// ----------------------------------------------------------------------------
module lpd_ctx_store #(
	parameter int DEPTH  = 16,
	parameter int ADDR_W = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [ADDR_W-1:0]  rd_addr,
	input  logic               wr_en,
	input  logic [ADDR_W-1:0]  wr_addr,
	input  lpd_pkg::lpd_ctx_t  wr_data,
	output lpd_pkg::lpd_ctx_t  rd_ctx
);

	lpd_pkg::lpd_ctx_t ctx_mem_q [DEPTH];
	logic [DEPTH-1:0]  vld_q;

	lpd_pkg::lpd_ctx_t rdata_s1;
	lpd_pkg::lpd_ctx_t fwd_s1;
	logic              vld_s1;
	logic              hit_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ctx_mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= ctx_mem_q[rd_addr];
			fwd_s1   <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld_s1 <= 1'b0;
			hit_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_s1 <= vld_q[rd_addr];
				// memory returns the old word when written in the read cycle
				hit_s1 <= wr_en && (wr_addr == rd_addr);
			end
		end
	end

	assign rd_ctx = hit_s1 ? fwd_s1 : (vld_s1 ? rdata_s1 : '0);

endmodule

FILE: rtl/core/lpd_step.sv
// ----------------------------------------------------------------------------
// lpd_step
// Context update for one transaction: header assembly, length check, body
// byte countdown and close reset. Produces the next context and at most one result.
// ----------------------------------------------------------------------------
module lpd_step (
	input  logic                        op,
	input  logic [lpd_pkg::CHAN_W-1:0]  channel,
	input  logic [lpd_pkg::BYTE_W-1:0]  data_byte,
	input  lpd_pkg::lpd_ctx_t           ctx,
	output lpd_pkg::lpd_ctx_t           ctx_next,
	output logic                        has_res,
	output lpd_pkg::lpd_res_t           res
);

	logic [lpd_pkg::ACC_W-1:0] hdr_acc;
	logic [lpd_pkg::ACC_W-1:0] body_left;

	assign hdr_acc   = {ctx.acc[lpd_pkg::ACC_W-lpd_pkg::BYTE_W-1:0], data_byte};
	assign body_left = ctx.acc - lpd_pkg::ACC_W'(1);

	always_comb begin
		ctx_next        = ctx;
		has_res         = 1'b0;
		res.kind        = lpd_pkg::KIND_BODY;
		res.out_channel = channel;
		res.body_byte   = '0;
		res.first       = 1'b0;
		res.last        = 1'b0;

		if (op == lpd_pkg::OP_CLOSE) begin
			ctx_next = '0;
		end else if (ctx.phase < lpd_pkg::PH_HDR_LAST) begin
			ctx_next.acc   = hdr_acc;
			ctx_next.phase = ctx.phase + lpd_pkg::PHASE_W'(1);
		end else if (ctx.phase == lpd_pkg::PH_HDR_LAST) begin
			// length complete: reject, report empty, or enter the body
			if (hdr_acc < lpd_pkg::HDR_BYTES) begin
				ctx_next = '0;
				has_res  = 1'b1;
				res.kind = lpd_pkg::KIND_ERROR;
			end else if (hdr_acc == lpd_pkg::HDR_BYTES) begin
				ctx_next = '0;
				has_res  = 1'b1;
				res.kind = lpd_pkg::KIND_EMPTY;
				res.last = 1'b1;
			end else begin
				ctx_next.acc   = hdr_acc - lpd_pkg::HDR_BYTES;
				ctx_next.phase = lpd_pkg::PH_BODY_FIRST;
			end
		end else begin
			has_res       = 1'b1;
			res.body_byte = data_byte;
			res.first     = (ctx.phase == lpd_pkg::PH_BODY_FIRST);
			res.last      = (body_left == '0);
			if (body_left == '0) begin
				ctx_next = '0;
			end else begin
				ctx_next.acc   = body_left;
				ctx_next.phase = lpd_pkg::PH_BODY_MORE;
			end
		end
	end

endmodule
